[design/clsr_pkg.sv]
// Shared types and constants for the combined shuffled random generator.
// Used by every module of the block but the RAM; no dependencies of its own.

package clsr_pkg;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned WARM_STEPS  = TABLE_DEPTH + 8;
  localparam int unsigned WARM_W      = $clog2(WARM_STEPS);

  localparam int unsigned VAL_W      = 31;
  localparam int unsigned FRAC_W     = 24;
  localparam int unsigned FRAC_SHIFT = VAL_W - FRAC_W;
  localparam int unsigned MUL_W      = 16;
  localparam int unsigned FOLD_W     = 8;
  localparam int unsigned LANES      = 2;

  // Both moduli sit just below 2^31: 2^31 - fold constant
  localparam logic [VAL_W-1:0]  MOD_ONE  = 31'd2147483563;
  localparam logic [VAL_W-1:0]  MOD_TWO  = 31'd2147483399;
  localparam logic [FOLD_W-1:0] FOLD_ONE = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD_TWO = 8'd249;
  localparam logic [MUL_W-1:0]  MUL_ONE  = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL_TWO  = 16'd40692;

  localparam logic [MUL_W-1:0]  LCG_MUL  [LANES] = '{MUL_ONE, MUL_TWO};
  localparam logic [VAL_W-1:0]  LCG_MOD  [LANES] = '{MOD_ONE, MOD_TWO};
  localparam logic [FOLD_W-1:0] LCG_FOLD [LANES] = '{FOLD_ONE, FOLD_TWO};

  localparam logic [VAL_W-1:0]  WRAP_ADD = 31'd2147483562;
  localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

  // Slot index = value / SLOT_DIV via reciprocal multiply plus one correction
  localparam logic [63:0] SLOT_DIV     = 64'(WRAP_ADD) / 64'(TABLE_DEPTH) + 64'd1;
  localparam int unsigned SLOT_SHIFT   = 40;
  localparam logic [63:0] SLOT_RECIP   = (64'd1 << SLOT_SHIFT) / SLOT_DIV;
  localparam int unsigned SLOT_RECIP_W = $clog2(SLOT_RECIP + 64'd1);
  localparam int unsigned SLOT_Q_W     = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_WARM_ISSUE,
    ST_WARM_WAIT,
    ST_DRAW,
    ST_DRAW_WAIT,
    ST_MIX,
    ST_FRAC,
    ST_FRAC_WAIT,
    ST_OUT
  } clsr_state_e;

endpackage

[design/clsr_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.

module clsr_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 31
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/clsr_lcg.sv]
// Two-lane pipelined modular multiplier stepping both generators, registered as product, fold and reduced result.
// Depends on clsr_pkg for multipliers, moduli and fold constants.

module clsr_lcg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [clsr_pkg::VAL_W-1:0] x1_i,
  input  logic [clsr_pkg::VAL_W-1:0] x2_i,
  output logic                      valid_o,
  output logic [clsr_pkg::VAL_W-1:0] y1_o,
  output logic [clsr_pkg::VAL_W-1:0] y2_o
);
  import clsr_pkg::*;

  localparam int unsigned PROD_W = VAL_W + MUL_W;

  logic [VAL_W-1:0]  x       [LANES];
  logic [PROD_W-1:0] prod_q  [LANES];
  logic [VAL_W:0]    fold_q  [LANES];
  logic [VAL_W:0]    fold2   [LANES];
  logic [VAL_W-1:0]  res_q   [LANES];
  logic [2:0]        vld_q;

  assign x[0] = x1_i;
  assign x[1] = x2_i;

  // Second fold and conditional subtract; the fold result is below 2^31
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (fold_q[l][VAL_W]) begin
        fold2[l] = (VAL_W+1)'(LCG_FOLD[l]) + (VAL_W+1)'(fold_q[l][VAL_W-1:0]);
      end else begin
        fold2[l] = (VAL_W+1)'(fold_q[l][VAL_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      prod_q[l] <= PROD_W'(x[l]) * PROD_W'(LCG_MUL[l]);
      // 2^31 == fold constant (mod m): fold the high part back in
      fold_q[l] <= (VAL_W+1)'(prod_q[l][PROD_W-1:VAL_W]) * (VAL_W+1)'(LCG_FOLD[l])
                 + (VAL_W+1)'(prod_q[l][VAL_W-1:0]);
      if (fold2[l] >= (VAL_W+1)'(LCG_MOD[l])) begin
        res_q[l] <= VAL_W'(fold2[l] - (VAL_W+1)'(LCG_MOD[l]));
      end else begin
        res_q[l] <= VAL_W'(fold2[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign y1_o    = res_q[0];
  assign y2_o    = res_q[1];

endmodule

[design/clsr_slot.sv]
// Shuffle slot index: previous output divided by the slot width, registered as product, estimate and clamped slot.
// Depends on clsr_pkg for the divisor, its reciprocal and the table depth.

module clsr_slot (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [clsr_pkg::VAL_W-1:0] x_i,
  output logic                      valid_o,
  output logic [clsr_pkg::IDX_W-1:0] slot_o
);
  import clsr_pkg::*;

  localparam int unsigned PW = VAL_W + SLOT_RECIP_W;

  logic [PW-1:0]       prod_q;
  logic [VAL_W-1:0]    x1_q;
  logic [VAL_W-1:0]    x2_q;
  logic [SLOT_Q_W-1:0] qe;
  logic [SLOT_Q_W-1:0] qe_q;
  logic [VAL_W:0]      qd_q;
  logic [VAL_W:0]      rem;
  logic [SLOT_Q_W:0]   q;
  logic [IDX_W-1:0]    slot_q;
  logic [2:0]          vld_q;

  // Estimate is exact or one short
  assign qe  = SLOT_Q_W'(prod_q >> SLOT_SHIFT);
  assign rem = {1'b0, x2_q} - qd_q;

  always_comb begin
    q = (SLOT_Q_W+1)'(qe_q);
    if (rem >= (VAL_W+1)'(SLOT_DIV)) begin
      q = q + (SLOT_Q_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(x_i) * PW'(SLOT_RECIP);
    x1_q   <= x_i;
    qe_q   <= qe;
    qd_q   <= (VAL_W+1)'(qe) * (VAL_W+1)'(SLOT_DIV);
    x2_q   <= x1_q;
    // Clamp to the last slot
    if (q >= (SLOT_Q_W+1)'(TABLE_DEPTH)) begin
      slot_q <= IDX_W'(TABLE_DEPTH - 1);
    end else begin
      slot_q <= q[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  assign valid_o = vld_q[2];
  assign slot_o  = slot_q;

endmodule

[design/clsr_frac.sv]
// Q0.24 fraction raw*2^24/MOD_ONE, clamped, via remainder and result registers; result holds.
// Depends on clsr_pkg for the modulus, fold constant and clamp value.

module clsr_frac (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [clsr_pkg::VAL_W-1:0]  raw_i,
  output logic                       valid_o,
  output logic [clsr_pkg::FRAC_W-1:0] frac_o
);
  import clsr_pkg::*;

  logic [FRAC_W-1:0] q0;
  logic [FRAC_W-1:0] q0_q;
  logic [VAL_W:0]    rem_q;
  logic [FRAC_W:0]   q1;
  logic [FRAC_W-1:0] frac_q;
  logic              v1_q;
  logic              v2_q;

  assign q0 = raw_i[VAL_W-1:FRAC_SHIFT];

  // raw*2^24 - q0*MOD_ONE stays below 2*MOD_ONE, so one correction step
  always_comb begin
    q1 = {1'b0, q0_q};
    if (rem_q >= (VAL_W+1)'(MOD_ONE)) begin
      q1 = q1 + (FRAC_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      q0_q  <= q0;
      rem_q <= (VAL_W+1)'({raw_i[FRAC_SHIFT-1:0], {FRAC_W{1'b0}}})
             + (VAL_W+1)'(q0) * (VAL_W+1)'(FOLD_ONE);
    end
    if (v1_q) begin
      if (q1 > (FRAC_W+1)'(FRAC_MAX)) begin
        frac_q <= FRAC_MAX;
      end else begin
        frac_q <= q1[FRAC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign frac_o  = frac_q;

endmodule

[design/combined_lcg_shuffle_rng.sv]
// Draw: one draw in flight, so a new request is accepted only after the last
// result is loaded into the output register (modular multiplier, table read
// and write-back, fraction scaling). A reseed, or the first draw after
// reset, first runs 40 warm-up steps through the multiplier.
// Reset clears control state and sets the seed to 1; the shuffle table needs
// no clearing, the warm-up fills it before any read.

module combined_lcg_shuffle_rng (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [clsr_pkg::VAL_W-1:0] cfg_wdata_i,    // seed_value
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [0] reseed
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [55:0]               m_axis_tdata    // [30:0] raw_value, [54:31] fraction
);
  import clsr_pkg::*;

  clsr_state_e       state_q, state_d;
  logic [VAL_W-1:0]  seed_q;
  logic [VAL_W-1:0]  g1_q, g1_d;
  logic [VAL_W-1:0]  g2_q, g2_d;
  logic [VAL_W-1:0]  last_q, last_d;
  logic              init_q, init_d;
  logic [WARM_W-1:0] warm_q, warm_d;
  logic [IDX_W-1:0]  slot_q, slot_d;

  logic              out_valid_q;
  logic [VAL_W-1:0]  out_raw_q;
  logic [FRAC_W-1:0] out_frac_q;
  logic              out_load;

  logic              lcg_vld, lcg_vld_o;
  logic [VAL_W-1:0]  y1, y2;
  logic              slot_vld, slot_vld_o;
  logic [IDX_W-1:0]  slot_o;
  logic              frac_vld, frac_vld_o;
  logic [FRAC_W-1:0] frac_o;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;

  logic [VAL_W-1:0]  seed_mod, seed_red;
  logic [VAL_W+1:0]  diff;
  logic [VAL_W+1:0]  mix_full;
  logic [VAL_W-1:0]  mix;

  clsr_lcg u_lcg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lcg_vld),
    .x1_i    (g1_q),
    .x2_i    (g2_q),
    .valid_o (lcg_vld_o),
    .y1_o    (y1),
    .y2_o    (y2)
  );

  clsr_slot u_slot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (slot_vld),
    .x_i     (last_q),
    .valid_o (slot_vld_o),
    .slot_o  (slot_o)
  );

  clsr_frac u_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (frac_vld),
    .raw_i   (last_q),
    .valid_o (frac_vld_o),
    .frac_o  (frac_o)
  );

  clsr_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (VAL_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_o),
    .rdata_o (ram_rdata)
  );

  // Reduce the seed once below MOD_ONE; zero becomes one
  always_comb begin
    if (seed_q >= MOD_ONE) begin
      seed_mod = seed_q - MOD_ONE;
    end else begin
      seed_mod = seed_q;
    end
    if (seed_mod == '0) begin
      seed_red = VAL_W'(1);
    end else begin
      seed_red = seed_mod;
    end
  end

  // Table entry minus second generator, wrapped into 1..WRAP_ADD
  always_comb begin
    diff = {2'b00, ram_rdata} - {2'b00, g2_q};
    if ($signed(diff) < $signed((VAL_W+2)'(1))) begin
      mix_full = diff + (VAL_W+2)'(WRAP_ADD);
    end else begin
      mix_full = diff;
    end
    mix = mix_full[VAL_W-1:0];
  end

  always_comb begin
    state_d   = state_q;
    g1_d      = g1_q;
    g2_d      = g2_q;
    last_d    = last_q;
    init_d    = init_q;
    warm_d    = warm_q;
    slot_d    = slot_q;
    lcg_vld   = 1'b0;
    slot_vld  = 1'b0;
    frac_vld  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = g1_q;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tdata[0] || init_q) begin
            state_d = ST_SEED;
          end else begin
            state_d = ST_DRAW;
          end
        end
      end
      ST_SEED: begin
        g1_d    = seed_red;
        g2_d    = seed_red;
        warm_d  = WARM_W'(WARM_STEPS - 1);
        state_d = ST_WARM_ISSUE;
      end
      ST_WARM_ISSUE: begin
        lcg_vld = 1'b1;
        state_d = ST_WARM_WAIT;
      end
      ST_WARM_WAIT: begin
        if (lcg_vld_o) begin
          g1_d = y1;
          // The last TABLE_DEPTH steps fill the table from the top down
          if (warm_q < WARM_W'(TABLE_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = warm_q[IDX_W-1:0];
            ram_wdata = y1;
          end
          if (warm_q == '0) begin
            last_d  = y1;
            init_d  = 1'b0;
            state_d = ST_DRAW;
          end else begin
            warm_d  = warm_q - WARM_W'(1);
            state_d = ST_WARM_ISSUE;
          end
        end
      end
      ST_DRAW: begin
        lcg_vld  = 1'b1;
        slot_vld = 1'b1;
        state_d  = ST_DRAW_WAIT;
      end
      ST_DRAW_WAIT: begin
        if (lcg_vld_o) begin
          g1_d    = y1;
          g2_d    = y2;
          slot_d  = slot_o;
          ram_re  = 1'b1;
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        // Read done last cycle; write the new first generator value back
        last_d  = mix;
        ram_we  = 1'b1;
        state_d = ST_FRAC;
      end
      ST_FRAC: begin
        frac_vld = 1'b1;
        state_d  = ST_FRAC_WAIT;
      end
      ST_FRAC_WAIT: begin
        if (frac_vld_o) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seed_q  <= VAL_W'(1);
      g1_q    <= '0;
      g2_q    <= '0;
      last_q  <= '0;
      init_q  <= 1'b1;
      warm_q  <= '0;
      slot_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      g1_q   <= g1_d;
      g2_q   <= g2_d;
      last_q <= last_d;
      init_q <= init_d;
      warm_q <= warm_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_raw_q  <= last_q;
      out_frac_q <= frac_o;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_frac_q, out_raw_q};

`ifndef NO_ASSERTIONS
  // Slot divider and generator step must finish in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) slot_vld_o |-> lcg_vld_o)
    else $error("slot result without generator result");

  // Mixing uses table data read in the cycle before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MIX) |-> $past(ram_re))
    else $error("mix without a table read");

  // An accepted transaction always leaves idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q != ST_IDLE))
    else $error("accepted transaction dropped");

  // Fraction results only arrive while waiting for them
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frac_vld_o |-> (state_q == ST_FRAC_WAIT))
    else $error("unexpected fraction result");
`endif

endmodule

[tb/sv/combined_lcg_shuffle_rng_tb.sv]
// Self-checking testbench for combined_lcg_shuffle_rng: streams draw requests,
// predicts every raw value and Q0.24 fraction, and compares each output transaction.
// Depends on clsr_pkg and the combined_lcg_shuffle_rng module.

module combined_lcg_shuffle_rng_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned GEN_A_MUL  = 64'd40014;
  localparam longint unsigned GEN_A_MOD  = 64'd2147483563;
  localparam longint unsigned GEN_B_MUL  = 64'd40692;
  localparam longint unsigned GEN_B_MOD  = 64'd2147483399;
  localparam longint          WRAP_SPAN  = 64'sd2147483562;
  localparam longint unsigned SLOT_WIDTH = 64'd67108862;
  localparam longint unsigned FRAC_TOP   = 64'd16777214;
  localparam int              SHUF_DEPTH = 32;
  localparam int              WARMUP     = SHUF_DEPTH + 8;
  localparam int              CYCLE_LIMIT = 1500000;
  localparam int              PHASES     = 6;
  localparam int              PHASE_DRAWS = 256;

  typedef struct packed {
    logic [30:0] raw;
    logic [23:0] frac;
  } draw_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [clsr_pkg::VAL_W-1:0]  cfg_wdata_i = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [7:0]                  s_axis_tdata = '0;     // [0] reseed
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [55:0]                 m_axis_tdata;         // [30:0] raw_value, [54:31] fraction

  combined_lcg_shuffle_rng dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Generator state as the block should hold it
  logic [30:0] seed_shadow = 31'd1;
  logic [30:0] gen_a = '0;
  logic [30:0] gen_b = '0;
  logic [30:0] prev_raw = '0;
  logic [30:0] shuf_tab [SHUF_DEPTH];
  bit          warm_pending = 1'b1;

  bit    reseed_q [$];
  draw_t draw_q [$];
  int    errors = 0;

  function automatic logic [30:0] lcg_step(input logic [30:0] x, input longint unsigned mul,
                                           input longint unsigned modulus);
    return 31'((mul * {33'd0, x}) % modulus);
  endfunction

  function automatic draw_t predict_draw(input bit reseed);
    longint unsigned start;
    longint          diff;
    longint unsigned slot;
    longint unsigned scaled;
    draw_t           d;
    if (reseed || warm_pending) begin
      start = {33'd0, seed_shadow} % GEN_A_MOD;
      if (start == 0) start = 1;
      gen_a = 31'(start);
      gen_b = 31'(start);
      // Run the warm-up; the last SHUF_DEPTH values fill the table from the top down
      for (int k = WARMUP - 1; k >= 0; k--) begin
        gen_a = lcg_step(gen_a, GEN_A_MUL, GEN_A_MOD);
        if (k < SHUF_DEPTH) shuf_tab[k] = gen_a;
      end
      prev_raw = shuf_tab[0];
      warm_pending = 1'b0;
    end
    gen_a = lcg_step(gen_a, GEN_A_MUL, GEN_A_MOD);
    gen_b = lcg_step(gen_b, GEN_B_MUL, GEN_B_MOD);
    slot = {33'd0, prev_raw} / SLOT_WIDTH;
    if (slot >= SHUF_DEPTH) slot = SHUF_DEPTH - 1;
    diff = $signed({33'd0, shuf_tab[slot]}) - $signed({33'd0, gen_b});
    shuf_tab[slot] = gen_a;
    if (diff < 1) diff = diff + WRAP_SPAN;
    prev_raw = diff[30:0];
    scaled = ({33'd0, prev_raw} << 24) / GEN_A_MOD;
    if (scaled > FRAC_TOP) scaled = FRAC_TOP;
    d.raw = prev_raw;
    d.frac = scaled[23:0];
    return d;
  endfunction

  // Request driver: bursts of random length, random gaps (sometimes none)
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (reseed_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, reseed_q.pop_front()};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: switch between always ready, random ready and long stall runs
  int  rx_mode = 0;
  int  mode_left = 0;
  int  run_left = 0;
  bit  rx_hold = 1'b1;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          if (run_left == 0) begin
            rx_hold = !rx_hold;
            run_left = rx_hold ? $urandom_range(1, 8) : $urandom_range(1, 15);
          end else begin
            run_left--;
          end
          m_axis_tready <= rx_hold;
        end
      endcase
    end
  end

  // Predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    draw_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        draw_q.insert(draw_q.size(), predict_draw(s_axis_tdata[0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (draw_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result transaction: expected none, actual raw %0d frac %0d",
                   $time, m_axis_tdata[30:0], m_axis_tdata[54:31]);
        end else begin
          want = draw_q.pop_front();
          if (m_axis_tdata[30:0] !== want.raw) begin
            errors++;
            $display("%0t: raw_value mismatch: expected %0d, actual %0d",
                     $time, want.raw, m_axis_tdata[30:0]);
          end
          if (m_axis_tdata[54:31] !== want.frac) begin
            errors++;
            $display("%0t: fraction mismatch: expected %0d, actual %0d",
                     $time, want.frac, m_axis_tdata[54:31]);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned n;
    for (n = 0; n < CYCLE_LIMIT; n++) @(posedge clk_i);
    $display("combined_lcg_shuffle_rng_tb: FAIL");
    $finish;
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (reseed_q.size() != 0 || s_axis_tvalid || draw_q.size() != 0);
  endtask

  // Write the seed register with no draw in flight
  task automatic load_seed(input logic [30:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    seed_shadow = value;
    @(negedge clk_i);
  endtask

  task automatic push_draws(input bit first_reseed, input int count, input int reseed_odds);
    reseed_q.insert(reseed_q.size(), first_reseed);
    for (int i = 1; i < count; i++) begin
      reseed_q.insert(reseed_q.size(), $urandom_range(1, reseed_odds) == 1);
    end
  endtask

  initial begin
    logic [30:0] seed;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset seed: first draw initializes without a reseed request
    reseed_q = '{1'b0, 1'b0, 1'b1, 1'b0};
    // Zero seed behaves as one
    load_seed(31'd0);
    reseed_q = '{1'b1, 1'b0};
    // Largest register value, reduced before use
    load_seed(31'h7FFFFFFF);
    reseed_q = '{1'b1, 1'b0, 1'b0};
    // Seed equal to the first modulus reduces to zero, then to one
    load_seed(31'd2147483563);
    reseed_q = '{1'b1, 1'b0};
    load_seed(31'd2147483562);
    reseed_q = '{1'b1, 1'b0, 1'b1};
    // Above the second modulus but below the first
    load_seed(31'd2147483450);
    reseed_q = '{1'b1, 1'b0, 1'b0};

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 5))
        0: seed = 31'd1;
        1: seed = 31'd2147483562 - 31'($urandom_range(0, 200));
        default: seed = 31'($urandom);
      endcase
      load_seed(seed);
      // Most phases restart on their first draw; some carry the old stream on
      push_draws(p % 3 != 2, PHASE_DRAWS, $urandom_range(3, 30));
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && draw_q.size() == 0) begin
      $display("combined_lcg_shuffle_rng_tb: PASS");
    end else begin
      $display("combined_lcg_shuffle_rng_tb: FAIL");
    end
    $finish;
  end

endmodule
